@@ src/go_to_point_heading_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Go-to-point controller assertion macros
// Shared macros for the concurrent checks of the controller.
// ----------------------------------------------------------------------------
`ifndef GO_TO_POINT_HEADING_CONTROLLER_ASSERT_SVH
`define GO_TO_POINT_HEADING_CONTROLLER_ASSERT_SVH

// Check that holds on every clock edge outside reset.
`define GTP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define GTP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/gtp_pkg.sv @@
// ----------------------------------------------------------------------------
// Go-to-point controller package
// Shared widths, constants, the arctangent table and the common types.
// ----------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;
   localparam int CNT_W            = $clog2(TABLE_LEN);
   localparam int XY_W             = 36;
   localparam int Z_W              = 28;
   localparam int ERR_W            = 18;
   localparam int ANG_SHIFT        = 11;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic signed [Z_W-1:0]   PI_Q24     = Z_W'(52707179);
   localparam logic signed [ERR_W-1:0] PI_Q13     = ERR_W'(25736);
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = ERR_W'(51472);

   localparam logic [2:0] CSR_TARGET_X      = 3'd0;
   localparam logic [2:0] CSR_TARGET_Y      = 3'd1;
   localparam logic [2:0] CSR_HEADING_TOL   = 3'd2;
   localparam logic [2:0] CSR_DISTANCE_TOL  = 3'd3;
   localparam logic [2:0] CSR_TURN_RATE     = 3'd4;
   localparam logic [2:0] CSR_FORWARD_SPEED = 3'd5;

   typedef enum logic [1:0] {
      MODE_ALIGN = 2'd0,
      MODE_DRIVE = 2'd1,
      MODE_STOP  = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic [14:0]        heading_tol;
      logic [30:0]        distance_tol;
      logic [14:0]        turn_rate;
      logic [19:0]        forward_speed;
   } cfg_type;

   typedef struct packed {
      logic                  on_target;
      logic signed [XY_W-1:0] x0;
      logic signed [XY_W-1:0] y0;
      logic signed [Z_W-1:0]  z0;
      logic [31:0]           ax;
      logic [31:0]           ay;
      logic signed [15:0]    heading;
   } work_type;

   function automatic logic [23:0] atan_q24(input logic [CNT_W-1:0] idx);
      logic [23:0] v;
      case (idx)
         5'd0:  v = 24'd13176795;
         5'd1:  v = 24'd7778716;
         5'd2:  v = 24'd4110060;
         5'd3:  v = 24'd2086331;
         5'd4:  v = 24'd1047214;
         5'd5:  v = 24'd524117;
         5'd6:  v = 24'd262123;
         5'd7:  v = 24'd131069;
         5'd8:  v = 24'd65536;
         5'd9:  v = 24'd32768;
         5'd10: v = 24'd16384;
         5'd11: v = 24'd8192;
         5'd12: v = 24'd4096;
         5'd13: v = 24'd2048;
         5'd14: v = 24'd1024;
         5'd15: v = 24'd512;
         5'd16: v = 24'd256;
         5'd17: v = 24'd128;
         5'd18: v = 24'd64;
         5'd19: v = 24'd32;
         5'd20: v = 24'd16;
         5'd21: v = 24'd8;
         5'd22: v = 24'd4;
         5'd23: v = 24'd2;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ src/gtp_req_if.sv @@
// ----------------------------------------------------------------------------
// Pose request channel
// Valid/ready channel that carries one robot pose per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic signed [15:0] heading;

   modport source (output valid, output pose_x, output pose_y, output heading,
                   input ready);
   modport sink   (input valid, input pose_x, input pose_y, input heading,
                   output ready);
endinterface

`default_nettype wire

@@ src/gtp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Motion command channel
// Valid/ready channel that carries one command result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] angular_cmd;
   logic [19:0]        linear_cmd;
   logic               cmd_valid;
   logic [1:0]         mode_now;
   logic               finished;

   modport source (output valid, output angular_cmd, output linear_cmd,
                   output cmd_valid, output mode_now, output finished,
                   input ready);
   modport sink   (input valid, input angular_cmd, input linear_cmd,
                   input cmd_valid, input mode_now, input finished,
                   output ready);
endinterface

`default_nettype wire

@@ src/gtp_front.sv @@
// ----------------------------------------------------------------------------
// Go-to-point front end
// Takes pose transfers, forms the offset to the target and folds it into
// the right half plane for the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_front
   import gtp_pkg::*;
(
   gtp_req_if.sink    req_bus,
   input  cfg_type    cfg,
   input  logic       queue_full,
   output logic       push,
   output work_type   work
);

   logic signed [33:0] dx;
   logic signed [33:0] dy;
   logic signed [33:0] ndx;
   logic signed [33:0] ndy;
   logic signed [33:0] xr;
   logic signed [33:0] yr;
   logic               left;

   assign dx   = 34'(cfg.target_x) - 34'(req_bus.pose_x);
   assign dy   = 34'(cfg.target_y) - 34'(req_bus.pose_y);
   assign ndx  = -dx;
   assign ndy  = -dy;
   assign left = dx[33];
   assign xr   = left ? ndx : dx;
   assign yr   = left ? ndy : dy;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   always_comb begin
      work.on_target = (dx == '0) && (dy == '0);
      work.x0        = XY_W'(xr);
      work.y0        = XY_W'(yr);
      work.z0        = left ? (dy[33] ? -PI_Q24 : PI_Q24) : '0;
      work.ax        = xr[31:0];
      work.ay        = dy[33] ? ndy[31:0] : dy[31:0];
      work.heading   = req_bus.heading;
   end

endmodule

`default_nettype wire

@@ src/gtp_queue.sv @@
// ----------------------------------------------------------------------------
// Go-to-point work queue
// Short queue of prepared items between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_queue
   import gtp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output work_type pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   work_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W:0]     count_ff;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ src/gtp_back.sv @@
// ----------------------------------------------------------------------------
// Go-to-point back end
// Runs the CORDIC bearing, the squared distances and the mode machine, and
// holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_back
   import gtp_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       work_ready,
   input  work_type   work,
   output logic       pop,
   gtp_rsp_if.source  rsp_bus
);

   localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_T,
      ST_ERROR,
      ST_DECIDE
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic signed [XY_W-1:0] x_ff;
   logic signed [XY_W-1:0] y_ff;
   logic signed [Z_W-1:0]  z_ff;
   logic                   on_target_ff;
   logic [31:0]            ax_ff;
   logic [31:0]            ay_ff;
   logic signed [15:0]     hd_ff;
   logic [63:0]            sx_ff;
   logic [63:0]            sy_ff;
   logic [63:0]            t2_ff;
   logic signed [ERR_W-1:0] err_ff;
   mode_type               mode_ff;
   logic                   stop_sent_ff;
   logic                   out_valid_ff;
   logic signed [15:0]     out_ang_ff;
   logic [19:0]            out_lin_ff;
   logic                   out_cmd_ff;
   mode_type               out_mode_ff;

   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic signed [Z_W-1:0]  at;
   logic [31:0]            mul_a;
   logic [31:0]            mul_b;
   logic [63:0]            prod;
   logic signed [Z_W-1:0]  z_round;
   logic signed [ERR_W-1:0] bearing;
   logic signed [ERR_W-1:0] err_raw;
   logic signed [ERR_W-1:0] err_wrap;
   logic [ERR_W-1:0]       aerr;
   logic                   big;
   logic [64:0]            d2;
   logic                   far;
   logic                   out_free;
   mode_type               dec_mode;
   logic                   dec_sent;
   logic                   dec_cmd;
   logic signed [15:0]     dec_ang;
   logic [19:0]            dec_lin;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = Z_W'(atan_q24(cnt_ff));

   always_comb begin
      case (state_ff)
         ST_MUL_X: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         ST_MUL_Y: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         default: begin
            mul_a = {1'b0, cfg.distance_tol};
            mul_b = {1'b0, cfg.distance_tol};
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   assign z_round = (z_ff + Z_W'(1 << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
   assign bearing = on_target_ff ? '0 : ERR_W'(z_round);
   assign err_raw = bearing - ERR_W'(hd_ff);

   always_comb begin
      if (err_raw > PI_Q13) begin
         err_wrap = err_raw - TWO_PI_Q13;
      end else if (err_raw < -PI_Q13) begin
         err_wrap = err_raw + TWO_PI_Q13;
      end else begin
         err_wrap = err_raw;
      end
   end

   assign aerr = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign big  = aerr > ERR_W'(cfg.heading_tol);
   assign d2   = {1'b0, sx_ff} + {1'b0, sy_ff};
   assign far  = d2 > {1'b0, t2_ff};

   always_comb begin
      dec_mode = mode_ff;
      dec_sent = stop_sent_ff;
      dec_cmd  = 1'b0;
      dec_ang  = '0;
      dec_lin  = '0;
      case (mode_ff)
         MODE_DRIVE: begin
            if (far) begin
               dec_lin = cfg.forward_speed;
               dec_cmd = 1'b1;
            end else begin
               dec_mode = MODE_STOP;
            end
            if (big) begin
               dec_mode = MODE_ALIGN;
            end
         end
         MODE_STOP: begin
            if (!stop_sent_ff) begin
               dec_cmd  = 1'b1;
               dec_sent = 1'b1;
            end
         end
         default: begin
            if (big) begin
               dec_ang  = (err_ff > 0) ? $signed({1'b0, cfg.turn_rate})
                                       : -$signed({1'b0, cfg.turn_rate});
               dec_cmd  = 1'b1;
               dec_mode = MODE_ALIGN;
            end else begin
               dec_mode = MODE_DRIVE;
            end
         end
      endcase
   end

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign pop      = (state_ff == ST_IDLE) && work_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_ALIGN;
         stop_sent_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_bus.ready && (state_ff != ST_DECIDE)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (work_ready) begin
                  x_ff         <= work.x0;
                  y_ff         <= work.y0;
                  z_ff         <= work.z0;
                  on_target_ff <= work.on_target;
                  ax_ff        <= work.ax;
                  ay_ff        <= work.ay;
                  hd_ff        <= work.heading;
                  cnt_ff       <= '0;
                  state_ff     <= ST_ROTATE;
               end
            end
            ST_ROTATE: begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + at;
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - at;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(STEPS - 1)) begin
                  state_ff <= ST_MUL_X;
               end
            end
            ST_MUL_X: begin
               sx_ff    <= prod;
               state_ff <= ST_MUL_Y;
            end
            ST_MUL_Y: begin
               sy_ff    <= prod;
               state_ff <= ST_MUL_T;
            end
            ST_MUL_T: begin
               t2_ff    <= prod;
               state_ff <= ST_ERROR;
            end
            ST_ERROR: begin
               err_ff   <= err_wrap;
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (out_free) begin
                  mode_ff      <= dec_mode;
                  stop_sent_ff <= dec_sent;
                  out_valid_ff <= 1'b1;
                  out_ang_ff   <= dec_ang;
                  out_lin_ff   <= dec_lin;
                  out_cmd_ff   <= dec_cmd;
                  out_mode_ff  <= dec_mode;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.angular_cmd = out_ang_ff;
   assign rsp_bus.linear_cmd  = out_lin_ff;
   assign rsp_bus.cmd_valid   = out_cmd_ff;
   assign rsp_bus.mode_now    = out_mode_ff;
   assign rsp_bus.finished    = (out_mode_ff == MODE_STOP);

endmodule

`default_nettype wire

@@ src/go_to_point_heading_controller.sv @@
// ----------------------------------------------------------------------------
// Go-to-point heading controller
// Turn-then-drive controller: one pose transfer in, one command transfer out.
//
// The req_bus channel takes one pose per transfer; the rsp_bus channel gives
// one result per pose, in order. Targets, tolerances and command magnitudes
// are written through the csr_ port, one register per write; the user must
// write them only while idle, as the block itself does not enforce this.
// A front end forms the target offset and places it in a two-entry queue, so
// up to two poses are taken while the back end is busy. The back end handles
// one pose at a time: it loads the pose, runs CORDIC_STEPS steps of the shared
// CORDIC rotator (capped at 24), uses the one shared multiplier for the
// squared offsets and the squared distance tolerance, then forms the
// heading error and decides. Results wait in an output register; when the
// receiver stalls, the back end holds its finished result in the decide
// step and the queue then fills and drops req_bus.ready.
// Reset clears the queue, the output register and the mode to align, and
// restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_point_heading_controller
   import gtp_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   gtp_req_if.sink     req_bus,
   gtp_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

`include "go_to_point_heading_controller_assert.svh"

   cfg_type  cfg_ff;
   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_ready;
   work_type push_data;
   work_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_x      <= '0;
         cfg_ff.target_y      <= '0;
         cfg_ff.heading_tol   <= 15'd143;
         cfg_ff.distance_tol  <= 31'd6554;
         cfg_ff.turn_rate     <= 15'd1638;
         cfg_ff.forward_speed <= 20'd32768;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_X:      cfg_ff.target_x      <= csr_wdata;
            CSR_TARGET_Y:      cfg_ff.target_y      <= csr_wdata;
            CSR_HEADING_TOL:   cfg_ff.heading_tol   <= csr_wdata[14:0];
            CSR_DISTANCE_TOL:  cfg_ff.distance_tol  <= csr_wdata[30:0];
            CSR_TURN_RATE:     cfg_ff.turn_rate     <= csr_wdata[14:0];
            CSR_FORWARD_SPEED: cfg_ff.forward_speed <= csr_wdata[19:0];
            default: begin
            end
         endcase
      end
   end

   gtp_front u_front (
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .work       (push_data)
   );

   gtp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_ready),
      .pop_data  (pop_data)
   );

   gtp_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_ready (queue_ready),
      .work       (pop_data),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

   `GTP_ASSERT(a_finished_mode, clock, reset, rsp_bus.valid |-> (rsp_bus.finished == (rsp_bus.mode_now == MODE_STOP)), "finished disagrees with mode")
   `GTP_ASSERT(a_idle_zero, clock, reset, (rsp_bus.valid && !rsp_bus.cmd_valid) |-> (rsp_bus.angular_cmd == 16'sd0 && rsp_bus.linear_cmd == 20'd0), "silent result carries a command")
   `GTP_ASSERT(a_turn_in_align, clock, reset, (rsp_bus.valid && rsp_bus.angular_cmd != 16'sd0) |-> (rsp_bus.mode_now == MODE_ALIGN && rsp_bus.linear_cmd == 20'd0), "turn command outside align")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Go-to-point controller testbench
// Drives pose transfers into the controller and predicts every command
// transfer with an independent model of the align, drive and stop modes and
// the CORDIC bearing. Results are checked in order while both channels idle
// at random and the registers are changed between traffic phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import gtp_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] h;
   } pose_type;

   typedef struct packed {
      logic signed [15:0] ang;
      logic [19:0]        lin;
      logic               cmd;
      logic [1:0]         mode;
      logic               fin;
   } command_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   gtp_req_if req_bus ();
   gtp_rsp_if rsp_bus ();

   go_to_point_heading_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   const longint arctan_q24[24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};

   cfg_type     model_cfg;
   mode_type    model_mode;
   logic        model_stop_sent;
   command_type expected_commands[$];
   int          error_count;
   int          cycle_count;
   int          stall_left;
   bit          steady_sink;
   bit          allow_arrival;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d commands outstanding", $time,
                  expected_commands.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic longint bearing_q13(longint dx, longint dy);
      longint x, y, z, xs, ys;
      if (dx == 0 && dy == 0) return 0;
      x = dx;
      y = dy;
      z = 0;
      if (dx < 0) begin
         x = -dx;
         y = -dy;
         z = (dy >= 0) ? 52707179 : -52707179;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_q24[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_q24[i];
         end
      end
      return (z + 1024) >>> 11;
   endfunction

   function automatic command_type control_tick(input pose_type p, input mode_type mode_in,
                                                input logic sent_in, output mode_type mode_out,
                                                output logic sent_out);
      command_type r;
      longint      dx, dy, err;
      logic [63:0] ax, ay, sx, sy, d2, t2;
      logic        big;
      dx = longint'(model_cfg.target_x) - longint'(p.x);
      dy = longint'(model_cfg.target_y) - longint'(p.y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sx = ax * ax;
      sy = ay * ay;
      d2 = sx + sy;
      if (d2 < sx) d2 = '1;
      t2 = 64'(model_cfg.distance_tol) * 64'(model_cfg.distance_tol);
      err = bearing_q13(dx, dy) - longint'(p.h);
      while (err > 25736) err = err - 51472;
      while (err < -25736) err = err + 51472;
      big = ((err < 0) ? -err : err) > longint'(model_cfg.heading_tol);
      r = '0;
      mode_out = mode_in;
      sent_out = sent_in;
      if (mode_in == MODE_DRIVE) begin
         if (d2 > t2) begin
            r.lin = model_cfg.forward_speed;
            r.cmd = 1'b1;
         end else begin
            mode_out = MODE_STOP;
         end
         if (big) mode_out = MODE_ALIGN;
      end else if (mode_in == MODE_STOP) begin
         if (!sent_in) begin
            r.cmd = 1'b1;
            sent_out = 1'b1;
         end
      end else begin
         if (big) begin
            r.ang = (err > 0) ? 16'(model_cfg.turn_rate) : -16'(model_cfg.turn_rate);
            r.cmd = 1'b1;
            mode_out = MODE_ALIGN;
         end else begin
            mode_out = MODE_DRIVE;
         end
      end
      r.mode = mode_out;
      r.fin = (mode_out == MODE_STOP);
      return r;
   endfunction

   task automatic send_pose(input pose_type p, input int gap);
      command_type c;
      mode_type    m;
      logic        s;
      c = control_tick(p, model_mode, model_stop_sent, m, s);
      while (!allow_arrival && m == MODE_STOP) begin
         p.x = model_cfg.target_x ^ 32'h8000_0000;
         c = control_tick(p, model_mode, model_stop_sent, m, s);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.pose_x  <= p.x;
      req_bus.pose_y  <= p.y;
      req_bus.heading <= p.h;
      do @(posedge clock); while (!req_bus.ready);
      expected_commands.push_back(c);
      model_mode = m;
      model_stop_sent = s;
   endtask

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_commands.size() != 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_TARGET_X:      model_cfg.target_x      = value;
         CSR_TARGET_Y:      model_cfg.target_y      = value;
         CSR_HEADING_TOL:   model_cfg.heading_tol   = value[14:0];
         CSR_DISTANCE_TOL:  model_cfg.distance_tol  = value[30:0];
         CSR_TURN_RATE:     model_cfg.turn_rate     = value[14:0];
         CSR_FORWARD_SPEED: model_cfg.forward_speed = value[19:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [15:0] heading_toward(input pose_type p, input int offset);
      longint b;
      b = bearing_q13(longint'(model_cfg.target_x) - longint'(p.x),
                      longint'(model_cfg.target_y) - longint'(p.y));
      return 16'(b + offset);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!steady_sink && $urandom_range(99) < 30)
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 8)
                                                   : $urandom_range(3, 1);
      end
   end

   always @(posedge clock) begin
      command_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.angular_cmd, rsp_bus.linear_cmd, rsp_bus.cmd_valid,
                rsp_bus.mode_now, rsp_bus.finished};
         if (expected_commands.size() == 0) begin
            $display("%0t: unexpected command transfer %p", $time, got);
            error_count <= error_count + 1;
         end else begin
            want = expected_commands.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected ang=%0d lin=%0d cmd=%0d mode=%0d fin=%0d",
                        $time, want.ang, want.lin, want.cmd, want.mode, want.fin);
               $display("%0t:            actual ang=%0d lin=%0d cmd=%0d mode=%0d fin=%0d",
                        $time, got.ang, got.lin, got.cmd, got.mode, got.fin);
               error_count <= error_count + 1;
            end
         end
      end
   end

   task automatic test_directed_cases();
      pose_type p;
      pose_type list[$];
      list = '{
         '{32'sh0001_0000, 32'sh0, 16'sh0},
         '{-32'sh0001_0000, 32'sh0, 16'sh0},
         '{-32'sh0001_0000, 32'sh0, 16'sh0},
         '{32'sh0, 32'sh0, 16'sh7FFF},
         '{32'sh0, 32'sh0, 16'sh0},
         '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -16'sh8000},
         '{-32'sh8000_0000, -32'sh8000_0000, 16'sh7FFF},
         '{32'sh7FFF_FFFF, -32'sh8000_0000, 16'sh6488},
         '{-32'sh8000_0000, 32'sh7FFF_FFFF, -16'sh6488},
         '{32'sh0, -32'sh0002_0000, 16'sh1000}};
      foreach (list[i]) send_pose(list[i], random_gap());
      wait_idle();
      write_register(CSR_TARGET_X, 32'h7FFF_FFFF);
      write_register(CSR_TARGET_Y, 32'h8000_0000);
      write_register(CSR_TURN_RATE, 32'hFFFF_FFFF);
      write_register(CSR_FORWARD_SPEED, 32'hFFFF_FFFF);
      write_register(CSR_HEADING_TOL, 32'd0);
      write_register(CSR_DISTANCE_TOL, 32'd0);
      p = '{-32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh0};
      send_pose(p, 0);
      p.h = heading_toward(p, 0);
      send_pose(p, 0);
      send_pose(p, 0);
      p.h = heading_toward(p, 1);
      send_pose(p, 0);
      wait_idle();
      write_register(CSR_HEADING_TOL, 32'h0000_6488);
      write_register(CSR_TURN_RATE, 32'd0);
      write_register(CSR_FORWARD_SPEED, 32'd0);
      p = '{32'sh1234_5678, -32'sh0765_4321, 16'sh7FFF};
      send_pose(p, 0);
      send_pose(p, 1);
      p.h = -16'sh8000;
      send_pose(p, 0);
      send_pose(p, 2);
      wait_idle();
   endtask

   task automatic test_random_phases();
      pose_type p;
      int       pick, tol;
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         steady_sink = (phase == 2);
         write_register(CSR_TARGET_X, (phase == 1) ? 32'h8000_0000 : $urandom());
         write_register(CSR_TARGET_Y, (phase == 1) ? 32'h7FFF_FFFF : $urandom());
         pick = $urandom_range(3);
         write_register(CSR_HEADING_TOL, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd25736
                        : {$urandom_range(65535), 16'(0)} | $urandom_range(2000));
         write_register(CSR_DISTANCE_TOL, {$urandom_range(255), 24'(0)} | $urandom_range(70000)
                        & 32'h80FF_FFFF);
         write_register(CSR_TURN_RATE, (phase == 3) ? 32'h7FFF : $urandom());
         write_register(CSR_FORWARD_SPEED, (phase == 4) ? 32'hF_FFFF : $urandom());
         tol = model_cfg.heading_tol;
         for (int n = 0; n < 250; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               p.x = $urandom();
               p.y = $urandom();
            end else if (pick < 85) begin
               p.x = model_cfg.target_x + $signed(32'($urandom_range(262144))) - 131072;
               p.y = model_cfg.target_y + $signed(32'($urandom_range(262144))) - 131072;
            end else begin
               p.x = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               p.y = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            pick = $urandom_range(99);
            if (pick < 65)
               p.h = heading_toward(p, int'($urandom_range(2 * tol + 4)) - tol - 2);
            else if (pick < 85)
               p.h = heading_toward(p, int'($urandom_range(51472)) - 25736);
            else
               p.h = $urandom();
            if (phase == 5 && n == 125) wait_idle();
            send_pose(p, (phase == 2 && n < 100) ? 0 : random_gap());
         end
      end
      steady_sink = 1'b0;
   endtask

   task automatic test_arrival();
      pose_type p;
      wait_idle();
      allow_arrival = 1'b1;
      write_register(CSR_TARGET_X, $urandom());
      write_register(CSR_TARGET_Y, $urandom());
      write_register(CSR_HEADING_TOL, 32'd143);
      write_register(CSR_DISTANCE_TOL, 32'hFFFF_FFFF);
      write_register(CSR_FORWARD_SPEED, 32'd32768);
      p.x = model_cfg.target_x + 32'sd3;
      p.y = model_cfg.target_y - 32'sd5;
      p.h = heading_toward(p, 0);
      send_pose(p, 0);
      send_pose(p, random_gap());
      for (int n = 0; n < 12; n++) begin
         p.x = $urandom();
         p.y = $urandom();
         p.h = $urandom();
         send_pose(p, random_gap());
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_TARGET_X;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.pose_x = '0;
      req_bus.pose_y = '0;
      req_bus.heading = '0;
      rsp_bus.ready  = 1'b0;
      error_count    = 0;
      cycle_count    = 0;
      steady_sink    = 1'b0;
      allow_arrival  = 1'b0;
      model_cfg      = '{target_x: 0, target_y: 0, heading_tol: 143, distance_tol: 6554,
                         turn_rate: 1638, forward_speed: 32768};
      model_mode      = MODE_ALIGN;
      model_stop_sent = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_phases();
      test_arrival();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_commands.size() != 0);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ go_to_point_heading_controller.f @@
+incdir+src
src/gtp_pkg.sv
src/gtp_req_if.sv
src/gtp_rsp_if.sv
src/gtp_front.sv
src/gtp_queue.sv
src/gtp_back.sv
src/go_to_point_heading_controller.sv
dv/tb_top.sv
